[hw/rtl/kt2x_pkg.sv]
// shared types and constants for the keyed table with top-two extremes
`timescale 1ns / 1ps

package kt2x_pkg;

   localparam int KEY_W   = 64;
   localparam int VALUE_W = 24;
   localparam int COUNT_W = 8;

   // request modes
   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_UPDATE = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_REPORT = 2'd3
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_DUP     = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   // what the datapath does with each word read during a sweep
   typedef enum logic [1:0] {
      OP_SEARCH = 2'd0,
      OP_SHIFT  = 2'd1,
      OP_SCAN1  = 2'd2,
      OP_SCAN2  = 2'd3
   } sweep_op_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_SHIFT,
      ST_SCAN1,
      ST_SCAN2
   } state_type;

   typedef struct packed {
      mode_type             mode;
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   entry_count;
      logic [VALUE_W-1:0]   old_value;
      logic [KEY_W-1:0]     min_key;
      logic [VALUE_W-1:0]   min_value;
      logic [KEY_W-1:0]     max_key;
      logic [VALUE_W-1:0]   max_value;
      logic [KEY_W-1:0]     second_min_key;
      logic [VALUE_W-1:0]   second_min_value;
      logic [KEY_W-1:0]     second_max_key;
      logic [VALUE_W-1:0]   second_max_value;
   } rsp_type;

   // one stored table entry
   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [VALUE_W-1:0]   value;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller to datapath commands
   typedef struct packed {
      logic         capture;
      logic         sweep_init;
      logic         sweep_from_pos;
      logic         sweep_run;
      sweep_op_type op;
      logic         decide;
      logic         shrink;
      logic         respond;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic sweep_done;
      logic delete_hit;
   } stat_type;

endpackage

[hw/rtl/kt2x_ram.sv]
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps

module kt2x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/kt2x_ctrl.sv]
// controller state machine sequencing search, update, shift and scans
`timescale 1ns / 1ps

module kt2x_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  kt2x_pkg::stat_type st,
   output kt2x_pkg::cmd_type  cmd,
   output logic               busy
);

   import kt2x_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (st.sweep_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = st.delete_hit ? ST_SHIFT : ST_SCAN1;
         end
         ST_SHIFT: begin
            if (st.sweep_done) state_in = ST_SCAN1;
         end
         ST_SCAN1: begin
            if (st.sweep_done) state_in = ST_SCAN2;
         end
         ST_SCAN2: begin
            if (st.sweep_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      cmd.op = OP_SEARCH;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture    = start;
            cmd.sweep_init = start;
         end
         ST_SEARCH: begin
            cmd.sweep_run = 1'b1;
            cmd.op        = OP_SEARCH;
         end
         ST_DECIDE: begin
            cmd.decide         = 1'b1;
            cmd.sweep_init     = 1'b1;
            cmd.sweep_from_pos = st.delete_hit;
         end
         ST_SHIFT: begin
            cmd.sweep_run  = 1'b1;
            cmd.op         = OP_SHIFT;
            cmd.shrink     = st.sweep_done;
            cmd.sweep_init = st.sweep_done;
         end
         ST_SCAN1: begin
            cmd.sweep_run  = 1'b1;
            cmd.op         = OP_SCAN1;
            cmd.sweep_init = st.sweep_done;
         end
         ST_SCAN2: begin
            cmd.sweep_run = 1'b1;
            cmd.op        = OP_SCAN2;
            cmd.respond   = st.sweep_done;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[hw/rtl/kt2x_datapath.sv]
// datapath: entry ram, sweep address counter, trackers and result register
`timescale 1ns / 1ps

module kt2x_datapath #(
   parameter int CAPACITY = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  kt2x_pkg::req_type  req_payload,
   input  kt2x_pkg::cmd_type  cmd,
   output kt2x_pkg::stat_type st,
   output logic               rsp_strobe,
   output kt2x_pkg::rsp_type  rsp_payload
);

   import kt2x_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // request and table bookkeeping
   req_type             req_ff;
   logic [CW-1:0]       fill_ff;
   status_type          status_ff;

   // sweep address pipeline
   logic [CW-1:0]       rd_idx_ff;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_at_ff;
   logic                issue;
   entry_type           rd_entry;

   // search results
   logic                found_ff;
   logic [AW-1:0]       pos_ff;
   logic [VALUE_W-1:0]  found_val_ff;

   // extreme trackers
   logic                have1_ff, have2min_ff, have2max_ff;
   logic [AW-1:0]       pmin_ff, pmax_ff;
   logic [KEY_W-1:0]    min_key_ff, max_key_ff, min2_key_ff, max2_key_ff;
   logic [VALUE_W-1:0]  min_val_ff, max_val_ff, min2_val_ff, max2_val_ff;

   // result register
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff;

   // decision of the captured request
   logic                full, ins_ok, upd_ok;
   status_type          status_calc;

   // ram ports
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   entry_type           wr_entry;
   logic                shift_wr;

   assign issue = cmd.sweep_run && (rd_idx_ff < fill_ff);

   kt2x_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   // status of the request once the search is done
   assign full   = (fill_ff == CW'(CAPACITY));
   assign ins_ok = (req_ff.mode == MODE_INSERT) && !full && !found_ff;
   assign upd_ok = (req_ff.mode == MODE_UPDATE) && found_ff;

   always_comb begin
      status_calc = STATUS_OK;
      unique case (req_ff.mode)
         MODE_INSERT: begin
            if (full)          status_calc = STATUS_FULL;
            else if (found_ff) status_calc = STATUS_DUP;
         end
         MODE_UPDATE, MODE_DELETE: begin
            if (!found_ff) status_calc = STATUS_MISSING;
         end
         MODE_REPORT: status_calc = STATUS_OK;
         default:     status_calc = STATUS_OK;
      endcase
   end

   assign st.sweep_done = !(rd_idx_ff < fill_ff) && !rd_vld_ff;
   assign st.delete_hit = (req_ff.mode == MODE_DELETE) && found_ff;

   // ram write: insert at the end, update in place, or move down one place
   assign shift_wr = rd_vld_ff && (cmd.op == OP_SHIFT);

   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = fill_ff[AW-1:0];
      wr_entry.key   = req_ff.key;
      wr_entry.value = req_ff.value;
      if (shift_wr) begin
         wr_en    = 1'b1;
         wr_addr  = rd_at_ff - AW'(1);
         wr_entry = rd_entry;
      end else if (cmd.decide && ins_ok) begin
         wr_en   = 1'b1;
         wr_addr = fill_ff[AW-1:0];
      end else if (cmd.decide && upd_ok) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
      end
   end

   // control registers: fill count, sweep counter, flags, strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rd_idx_ff     <= '0;
         rd_vld_ff     <= 1'b0;
         found_ff      <= 1'b0;
         have1_ff      <= 1'b0;
         have2min_ff   <= 1'b0;
         have2max_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
         if (cmd.decide && ins_ok) begin
            fill_ff <= fill_ff + CW'(1);
         end else if (cmd.shrink) begin
            fill_ff <= fill_ff - CW'(1);
         end
         if (cmd.sweep_init) begin
            rd_idx_ff <= cmd.sweep_from_pos ? (CW'(pos_ff) + CW'(1)) : '0;
            rd_vld_ff <= 1'b0;
         end else begin
            if (issue) rd_idx_ff <= rd_idx_ff + CW'(1);
            rd_vld_ff <= issue;
         end
         if (cmd.capture) begin
            found_ff    <= 1'b0;
            have1_ff    <= 1'b0;
            have2min_ff <= 1'b0;
            have2max_ff <= 1'b0;
         end else if (rd_vld_ff) begin
            unique case (cmd.op)
               OP_SEARCH: begin
                  if (rd_entry.key == req_ff.key) found_ff <= 1'b1;
               end
               OP_SCAN1: have1_ff <= 1'b1;
               OP_SCAN2: begin
                  if (rd_at_ff != pmin_ff) have2min_ff <= 1'b1;
                  if (rd_at_ff != pmax_ff) have2max_ff <= 1'b1;
               end
               OP_SHIFT: ;
               default: ;
            endcase
         end
      end
   end

   // payload registers: request, read position, status, search hit and trackers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (issue) begin
         rd_at_ff <= rd_idx_ff[AW-1:0];
      end
      if (cmd.decide) begin
         status_ff <= status_calc;
      end
      if (rd_vld_ff && !cmd.capture) begin
         unique case (cmd.op)
            OP_SEARCH: begin
               // first matching entry only
               if (!found_ff && rd_entry.key == req_ff.key) begin
                  pos_ff       <= rd_at_ff;
                  found_val_ff <= rd_entry.value;
               end
            end
            OP_SCAN1: begin
               if (!have1_ff || rd_entry.value < min_val_ff) begin
                  min_val_ff <= rd_entry.value;
                  min_key_ff <= rd_entry.key;
                  pmin_ff    <= rd_at_ff;
               end
               if (!have1_ff || rd_entry.value > max_val_ff) begin
                  max_val_ff <= rd_entry.value;
                  max_key_ff <= rd_entry.key;
                  pmax_ff    <= rd_at_ff;
               end
            end
            OP_SCAN2: begin
               // skip the entry that won the first pass
               if (rd_at_ff != pmin_ff &&
                   (!have2min_ff || rd_entry.value < min2_val_ff)) begin
                  min2_val_ff <= rd_entry.value;
                  min2_key_ff <= rd_entry.key;
               end
               if (rd_at_ff != pmax_ff &&
                   (!have2max_ff || rd_entry.value > max2_val_ff)) begin
                  max2_val_ff <= rd_entry.value;
                  max2_key_ff <= rd_entry.key;
               end
            end
            OP_SHIFT: ;
            default: ;
         endcase
      end
   end

   // result beat assembly; missing extremes read as zero
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status           <= status_ff;
         rsp_ff.entry_count      <= COUNT_W'(fill_ff);
         rsp_ff.old_value        <= upd_ok ? found_val_ff : '0;
         rsp_ff.min_key          <= have1_ff ? min_key_ff : '0;
         rsp_ff.min_value        <= have1_ff ? min_val_ff : '0;
         rsp_ff.max_key          <= have1_ff ? max_key_ff : '0;
         rsp_ff.max_value        <= have1_ff ? max_val_ff : '0;
         rsp_ff.second_min_key   <= have2min_ff ? min2_key_ff : '0;
         rsp_ff.second_min_value <= have2min_ff ? min2_val_ff : '0;
         rsp_ff.second_max_key   <= have2max_ff ? max2_key_ff : '0;
         rsp_ff.second_max_value <= have2max_ff ? max2_val_ff : '0;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hw/rtl/keyed_table_with_top_two_extremes.sv]
// top level: keyed table with top-two extremes search
//
//   channel   ports                        handshake
//   request   start, busy, req_payload     taken when start high and busy low
//   result    rsp_strobe, rsp_payload      one beat per request, one cycle wide
//
// each sweep reads the stored entries in order through the single read port of the
// entry ram; a request runs key search, decide, an optional shift down on a delete
// that hits, and two extreme scans
// reset clears the fill count, flags and controller state, not the entry ram contents
// the result beat comes in the cycle after the last scan ends, as busy falls
// the receiver cannot stall; a new request may be started in that same cycle
`timescale 1ns / 1ps

module keyed_table_with_top_two_extremes #(
   parameter int CAPACITY = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  kt2x_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output kt2x_pkg::rsp_type rsp_payload
);

   import kt2x_pkg::*;

   cmd_type  cmd;
   stat_type st;

   // controller
   kt2x_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .st    (st),
      .cmd   (cmd),
      .busy  (busy)
   );

   // datapath
   kt2x_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .st          (st),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // an accepted request keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a request");

   // the result beat appears only as the controller returns to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while still busy");

   // one result per request: never two beats back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result beat repeated");

   // sweep commands come only while a request is in work
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep_run || cmd.decide) |-> busy)
      else $error("datapath command while idle");

endmodule

[tb/sv/keyed_table_with_top_two_extremes_tb.sv]
// testbench for the keyed table with top-two extremes: directed and random table traffic, self-checked
`timescale 1ns / 1ps

module keyed_table_with_top_two_extremes_tb;
   import kt2x_pkg::*;

   localparam int TABLE_DEPTH  = 128;
   localparam int RANDOM_ITEMS = 530;
   localparam int STALL_LIMIT  = 4096;
   localparam int TAIL_CYCLES  = 600;

   typedef struct {
      req_type     req;
      int unsigned gap;
      bit          hold;
   } planned_beat_type;

   typedef enum {
      PH_FILL,
      PH_CHURN,
      PH_EMPTY
   } traffic_phase_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   // table mirror used for prediction
   logic [KEY_W-1:0]   tbl_key [TABLE_DEPTH];
   logic [VALUE_W-1:0] tbl_val [TABLE_DEPTH];
   int                 tbl_fill = 0;

   planned_beat_type   req_backlog [$];
   rsp_type            due_results [$];
   logic [KEY_W-1:0]   live_keys [$];

   planned_beat_type   cur_beat;
   bit                 have_cur    = 1'b0;
   int unsigned        gap_left    = 0;
   logic               start_next;
   int unsigned        n_sent      = 0;
   int unsigned        n_seen      = 0;
   int unsigned        error_count = 0;
   int unsigned        idle_cycles = 0;
   int unsigned        calm_left   = 0;
   bit                 calm_burst  = 1'b0;

   keyed_table_with_top_two_extremes #(
      .CAPACITY(TABLE_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // position of a key in the mirror, -1 if absent
   function automatic int find_key(input logic [KEY_W-1:0] k);
      for (int i = 0; i < tbl_fill; i++) begin
         if (tbl_key[i] == k) begin
            return i;
         end
      end
      return -1;
   endfunction

   // earliest smallest or largest entry, skipping one position
   function automatic int find_extreme(input bit want_max, input int skip);
      int best;
      best = -1;
      for (int i = 0; i < tbl_fill; i++) begin
         if (i == skip) begin
            continue;
         end
         if (best < 0) begin
            best = i;
         end else if (want_max ? (tbl_val[i] > tbl_val[best])
                               : (tbl_val[i] < tbl_val[best])) begin
            best = i;
         end
      end
      return best;
   endfunction

   // apply one request to the mirror and build the result it should produce
   function automatic rsp_type apply_to_table(input req_type rq);
      rsp_type rs;
      int      hit;
      int      lo;
      int      hi;
      int      lo2;
      int      hi2;
      rs = '0;
      rs.status = STATUS_OK;
      hit = find_key(rq.key);
      case (rq.mode)
         MODE_INSERT: begin
            if (tbl_fill >= TABLE_DEPTH) begin
               rs.status = STATUS_FULL;
            end else if (hit >= 0) begin
               rs.status = STATUS_DUP;
            end else begin
               tbl_key[tbl_fill] = rq.key;
               tbl_val[tbl_fill] = rq.value;
               tbl_fill++;
            end
         end
         MODE_UPDATE: begin
            if (hit < 0) begin
               rs.status = STATUS_MISSING;
            end else begin
               rs.old_value = tbl_val[hit];
               tbl_val[hit] = rq.value;
            end
         end
         MODE_DELETE: begin
            if (hit < 0) begin
               rs.status = STATUS_MISSING;
            end else begin
               for (int i = hit; i < tbl_fill - 1; i++) begin
                  tbl_key[i] = tbl_key[i+1];
                  tbl_val[i] = tbl_val[i+1];
               end
               tbl_fill--;
            end
         end
         default: begin
         end
      endcase
      rs.entry_count = tbl_fill[COUNT_W-1:0];
      lo  = find_extreme(1'b0, -1);
      hi  = find_extreme(1'b1, -1);
      lo2 = (lo >= 0) ? find_extreme(1'b0, lo) : -1;
      hi2 = (hi >= 0) ? find_extreme(1'b1, hi) : -1;
      if (lo >= 0) begin
         rs.min_key   = tbl_key[lo];
         rs.min_value = tbl_val[lo];
      end
      if (hi >= 0) begin
         rs.max_key   = tbl_key[hi];
         rs.max_value = tbl_val[hi];
      end
      if (lo2 >= 0) begin
         rs.second_min_key   = tbl_key[lo2];
         rs.second_min_value = tbl_val[lo2];
      end
      if (hi2 >= 0) begin
         rs.second_max_key   = tbl_key[hi2];
         rs.second_max_value = tbl_val[hi2];
      end
      return rs;
   endfunction

   // position of a key among the keys the stimulus believes are stored
   function automatic int live_index(input logic [KEY_W-1:0] k);
      for (int i = 0; i < live_keys.size(); i++) begin
         if (live_keys[i] == k) begin
            return i;
         end
      end
      return -1;
   endfunction

   // queue one request, tracking the stored keys and drawing the idle gap
   task automatic queue_item(input mode_type m, input logic [KEY_W-1:0] k,
                             input logic [VALUE_W-1:0] v, input bit hold);
      planned_beat_type pb;
      int               idx;
      idx = live_index(k);
      if (m == MODE_INSERT && live_keys.size() < TABLE_DEPTH && idx < 0) begin
         live_keys.push_back(k);
      end else if (m == MODE_DELETE && idx >= 0) begin
         live_keys.delete(idx);
      end
      // alternate stretches of back-to-back beats with randomly gapped ones
      if (calm_left == 0) begin
         calm_burst = ($urandom_range(0, 2) == 0);
         calm_left  = $urandom_range(5, 30);
      end
      calm_left--;
      pb.req.mode  = m;
      pb.req.key   = k;
      pb.req.value = v;
      pb.gap       = calm_burst ? 0 : $urandom_range(0, 15);
      pb.hold      = hold;
      req_backlog.push_back(pb);
   endtask

   // values biased toward ties and the extremes
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return '1;
      end else if (r < 4) begin
         return VALUE_W'($urandom_range(1, 4) * 24'h001000);
      end
      return VALUE_W'($urandom);
   endfunction

   function automatic logic [KEY_W-1:0] fresh_key();
      if ($urandom_range(0, 9) == 0) begin
         return KEY_W'($urandom_range(0, 3));
      end
      return {$urandom, $urandom};
   endfunction

   // stimulus, reset and end of run
   initial begin
      traffic_phase_type phase;
      int unsigned       full_seen;
      int unsigned       churn_left;
      int unsigned       r;
      int unsigned       ins_pct;
      int unsigned       upd_pct;
      int unsigned       del_pct;
      mode_type          m;
      logic [KEY_W-1:0]  k;
      bit                hold;

      // directed: empty table, single entry, ties, duplicates, missing keys
      queue_item(MODE_REPORT, '0, '0, 1'b0);
      queue_item(MODE_UPDATE, 64'h1234, 24'h55, 1'b0);
      queue_item(MODE_DELETE, '1, '0, 1'b0);
      queue_item(MODE_INSERT, '0, '0, 1'b0);
      queue_item(MODE_REPORT, '1, '1, 1'b0);
      queue_item(MODE_INSERT, '1, '1, 1'b0);
      queue_item(MODE_INSERT, '0, 24'h777, 1'b0);
      queue_item(MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, '1, 1'b0);
      queue_item(MODE_INSERT, 64'h5555_5555_5555_5555, '0, 1'b0);
      queue_item(MODE_INSERT, 64'h0000_0001_0000_0001, 24'hAAAAAA, 1'b0);
      queue_item(MODE_INSERT, 64'h8000_0000_0000_0000, 24'h555555, 1'b0);
      queue_item(MODE_UPDATE, '1, 24'h000005, 1'b0);
      queue_item(MODE_UPDATE, '0, '0, 1'b0);
      queue_item(MODE_UPDATE, 64'h5555_5555_5555_5555, '1, 1'b0);
      queue_item(MODE_DELETE, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0);
      queue_item(MODE_DELETE, '0, '1, 1'b0);
      queue_item(MODE_DELETE, 64'h8000_0000_0000_0000, '0, 1'b0);
      queue_item(MODE_DELETE, 64'h8000_0000_0000_0000, '0, 1'b0);
      queue_item(MODE_DELETE, '1, '0, 1'b0);
      queue_item(MODE_DELETE, 64'h5555_5555_5555_5555, '0, 1'b0);
      queue_item(MODE_REPORT, '0, '0, 1'b0);
      queue_item(MODE_DELETE, 64'h0000_0001_0000_0001, '0, 1'b0);
      queue_item(MODE_REPORT, '1, '1, 1'b0);

      // random: fill to full, churn, empty out, churn, and so on
      phase      = PH_FILL;
      full_seen  = 0;
      churn_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         hold = (n == 0) || ($urandom_range(0, 49) == 0);
         case (phase)
            PH_FILL: begin
               if (live_keys.size() == TABLE_DEPTH) begin
                  full_seen++;
               end
               if (full_seen >= 10) begin
                  phase      = PH_CHURN;
                  churn_left = 70;
                  full_seen  = 0;
                  hold       = 1'b1;
               end
            end
            PH_CHURN: begin
               if (churn_left == 0) begin
                  phase = (live_keys.size() > 40) ? PH_EMPTY : PH_FILL;
                  hold  = 1'b1;
               end else begin
                  churn_left--;
               end
            end
            default: begin
               if (live_keys.size() == 0) begin
                  phase      = PH_CHURN;
                  churn_left = 40;
                  hold       = 1'b1;
               end
            end
         endcase
         case (phase)
            PH_FILL: begin
               ins_pct = 85;
               upd_pct = 5;
               del_pct = 5;
            end
            PH_CHURN: begin
               ins_pct = 35;
               upd_pct = 25;
               del_pct = 30;
            end
            default: begin
               ins_pct = 5;
               upd_pct = 10;
               del_pct = 80;
            end
         endcase
         r = $urandom_range(0, 99);
         if (r < ins_pct) begin
            m = MODE_INSERT;
         end else if (r < ins_pct + upd_pct) begin
            m = MODE_UPDATE;
         end else if (r < ins_pct + upd_pct + del_pct) begin
            m = MODE_DELETE;
         end else begin
            m = MODE_REPORT;
         end
         // mostly stored keys for update and delete, mostly new ones for insert
         if (live_keys.size() != 0 &&
             ((m == MODE_INSERT && $urandom_range(0, 4) == 0) ||
              (m != MODE_INSERT && $urandom_range(0, 9) != 0))) begin
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
         end else begin
            k = fresh_key();
         end
         queue_item(m, k, pick_value(), hold);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (!(req_backlog.size() == 0 && !have_cur && !start && n_seen == n_sent)) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("results still outstanding at end: %0d", due_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         start_next = start;
         // beat taken: predict its result
         if (start && !busy) begin
            due_results.push_back(apply_to_table(cur_beat.req));
            n_sent++;
            have_cur   = 1'b0;
            start_next = 1'b0;
         end
         if (!have_cur && req_backlog.size() != 0) begin
            cur_beat = req_backlog.pop_front();
            gap_left = cur_beat.gap;
            have_cur = 1'b1;
         end
         // wait out the gap, and for a held beat until the table is quiet
         if (have_cur && !start_next) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (!cur_beat.hold || n_sent == n_seen) begin
               start_next = 1'b1;
               req_payload <= cur_beat.req;
            end
         end
         start <= start_next;
      end
   end

   task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         n_seen <= n_seen + 1;
         if (due_results.size() == 0) begin
            $error("result beat with nothing outstanding");
            error_count++;
         end else begin
            want = due_results.pop_front();
            check_field("status", want.status, rsp_payload.status);
            check_field("entry_count", want.entry_count, rsp_payload.entry_count);
            check_field("old_value", want.old_value, rsp_payload.old_value);
            check_field("min_key", want.min_key, rsp_payload.min_key);
            check_field("min_value", want.min_value, rsp_payload.min_value);
            check_field("max_key", want.max_key, rsp_payload.max_key);
            check_field("max_value", want.max_value, rsp_payload.max_value);
            check_field("second_min_key", want.second_min_key,
                        rsp_payload.second_min_key);
            check_field("second_min_value", want.second_min_value,
                        rsp_payload.second_min_value);
            check_field("second_max_key", want.second_max_key,
                        rsp_payload.second_max_key);
            check_field("second_max_value", want.second_max_value,
                        rsp_payload.second_max_value);
         end
      end
   end

   // watchdog on cycles with no beat in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

[filelist.f]
hw/rtl/kt2x_pkg.sv
hw/rtl/kt2x_ram.sv
hw/rtl/kt2x_ctrl.sv
hw/rtl/kt2x_datapath.sv
hw/rtl/keyed_table_with_top_two_extremes.sv
tb/sv/keyed_table_with_top_two_extremes_tb.sv
